@@ rtl/lla_pkg.sv @@
// Shared types and constants for the life-like automaton stepper.
// Used by the controller, the datapath and the top level; no dependencies.
package lla_pkg;

  localparam int MAX_SIDE_DEF = 128;

  localparam logic [1:0] CFG_BIRTH   = 2'd0;
  localparam logic [1:0] CFG_SURVIVE = 2'd1;
  localparam logic [1:0] CFG_SIDE    = 2'd2;

  localparam logic [8:0] BIRTH_RST   = 9'd8;
  localparam logic [8:0] SURVIVE_RST = 9'd12;
  localparam logic [7:0] SIDE_RST    = 8'd40;

  typedef enum logic [1:0] {
    CMD_TOGGLE = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_STEP   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TOGGLE,
    PH_SCAN,
    PH_STEP
  } phase_t;

  typedef struct packed {
    logic [1:0] command;
    logic [6:0] row;
    logic [6:0] col;
  } req_t;

  typedef struct packed {
    logic running;
    logic any_alive;
    logic unchanged;
    logic cell_value;
  } rsp_t;

  typedef struct packed {
    logic   load;
    logic   restart;
    phase_t phase;
  } ctl_t;

  typedef struct packed {
    logic last;
  } sts_t;

endpackage

@@ rtl/lla_grid_mem.sv @@
// Grid row store: one write port, one registered read port, per-row valid bits.
// Rows never written since reset or the last clear read as all dead. No dependencies.
module lla_grid_mem #(
  parameter int ROWS  = 128,
  parameter int WIDTH = 128
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     clear_all,
  input  logic                     rd_en,
  input  logic [$clog2(ROWS)-1:0]  rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(ROWS)-1:0]  wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [ROWS];
  logic [ROWS-1:0]  row_valid;
  logic [WIDTH-1:0] data_q;
  logic             vld_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      data_q <= mem[rd_addr];
      vld_q  <= row_valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = vld_q ? data_q : '0;

endmodule

@@ rtl/lla_ctrl.sv @@
// Command sequencer: walks toggle, scan and step phases of the datapath.
// Depends on lla_pkg.
module lla_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [1:0]    command,
  input  lla_pkg::sts_t sts,
  output lla_pkg::ctl_t ctl,
  output logic          busy,
  output logic          done
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TOGGLE,
    S_SCAN,
    S_STEP,
    S_DONE
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            case (command)
              lla_pkg::CMD_TOGGLE: state <= S_TOGGLE;
              lla_pkg::CMD_CLEAR:  state <= S_DONE;
              lla_pkg::CMD_STEP:   state <= S_STEP;
              default:             state <= S_SCAN;
            endcase
          end
        end
        S_TOGGLE: if (sts.last) state <= S_SCAN;
        S_SCAN:   if (sts.last) state <= S_DONE;
        S_STEP:   if (sts.last) state <= S_DONE;
        S_DONE:   state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    busy        = (state != S_IDLE);
    done        = (state == S_DONE);
    ctl.load    = start && (state == S_IDLE);
    ctl.restart = (state == S_TOGGLE) && sts.last;
    case (state)
      S_TOGGLE: ctl.phase = lla_pkg::PH_TOGGLE;
      S_SCAN:   ctl.phase = lla_pkg::PH_SCAN;
      S_STEP:   ctl.phase = lla_pkg::PH_STEP;
      default:  ctl.phase = lla_pkg::PH_IDLE;
    endcase
  end

  a_done_then_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("done not followed by idle");
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    ctl.load |=> busy) else $error("accepted command left block idle");
  a_restart_to_scan: assert property (@(posedge clk) disable iff (rst)
    ctl.restart |=> (ctl.phase == lla_pkg::PH_SCAN)) else $error("toggle not followed by scan");

endmodule

@@ rtl/lla_datapath.sv @@
// Row-streaming datapath: three-row window, neighbour count and rule per column,
// toggle and liveness scan. Depends on lla_pkg and lla_grid_mem.
module lla_datapath #(
  parameter int MAX_SIDE = lla_pkg::MAX_SIDE_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  lla_pkg::ctl_t ctl,
  input  lla_pkg::req_t req,
  input  logic [8:0]    birth_mask,
  input  logic [8:0]    survive_mask,
  input  logic [7:0]    grid_side,
  output lla_pkg::sts_t sts,
  output lla_pkg::rsp_t rsp
);

  localparam int AW = $clog2(MAX_SIDE);
  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int TW = $clog2(MAX_SIDE + 4);

  logic [SW-1:0]       side_c;
  logic [SW-1:0]       side_q;
  logic [AW-1:0]       side_m1;
  logic [TW-1:0]       t;
  logic [6:0]          row_q;
  logic [6:0]          col_q;
  logic                in_rng_q;
  logic                running;
  logic                alive;
  logic                same;
  logic                cell_val;
  logic [MAX_SIDE-1:0] win_prev;
  logic [MAX_SIDE-1:0] win_cur;
  logic [MAX_SIDE-1:0] win_nxt;
  logic [MAX_SIDE-1:0] row0_q;
  logic [MAX_SIDE-1:0] col_mask;
  logic [MAX_SIDE-1:0] new_row;
  logic [MAX_SIDE-1:0] onehot;
  logic                chg;
  logic                new_any;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [MAX_SIDE-1:0] rd_data;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [MAX_SIDE-1:0] wr_data;
  logic                clear_all;
  logic                tgl_bit;
  logic                in_step;
  logic                step_wr;
  logic                scan_acc;

  lla_grid_mem #(.ROWS(MAX_SIDE), .WIDTH(MAX_SIDE)) u_mem (
    .clk       (clk),
    .rst       (rst),
    .clear_all (clear_all),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  always_comb begin
    if (grid_side < 8'd2) begin
      side_c = SW'(2);
    end else if (32'(grid_side) > MAX_SIDE) begin
      side_c = SW'(MAX_SIDE);
    end else begin
      side_c = SW'(grid_side);
    end
  end

  assign side_m1 = AW'(side_q - SW'(1));

  always_comb begin
    for (int c = 0; c < MAX_SIDE; c++) begin
      col_mask[c] = (c < int'(side_q));
    end
  end

  // next-generation row from the window, wrapping at the side in use
  always_comb begin
    logic       lp, lu, ln, rp, ru, rn, nb;
    logic [3:0] n;
    for (int c = 0; c < MAX_SIDE; c++) begin
      if (c == 0) begin
        lp = win_prev[side_m1];
        lu = win_cur[side_m1];
        ln = win_nxt[side_m1];
      end else begin
        lp = win_prev[(c + MAX_SIDE - 1) % MAX_SIDE];
        lu = win_cur[(c + MAX_SIDE - 1) % MAX_SIDE];
        ln = win_nxt[(c + MAX_SIDE - 1) % MAX_SIDE];
      end
      if (c == int'(side_q) - 1) begin
        rp = win_prev[0];
        ru = win_cur[0];
        rn = win_nxt[0];
      end else begin
        rp = win_prev[(c + 1) % MAX_SIDE];
        ru = win_cur[(c + 1) % MAX_SIDE];
        rn = win_nxt[(c + 1) % MAX_SIDE];
      end
      n = 4'(lp) + 4'(win_prev[c]) + 4'(rp) + 4'(lu) + 4'(ru)
        + 4'(ln) + 4'(win_nxt[c]) + 4'(rn);
      nb = win_cur[c] ? survive_mask[n] : birth_mask[n];
      new_row[c] = col_mask[c] ? nb : win_cur[c];
    end
  end

  assign chg     = |(new_row ^ win_cur);
  assign new_any = |(new_row & col_mask);
  assign onehot  = {{(MAX_SIDE-1){1'b0}}, 1'b1} << col_q;
  assign tgl_bit = rd_data[AW'(col_q)];

  assign in_step  = (ctl.phase == lla_pkg::PH_STEP);
  assign step_wr  = in_step && (t >= TW'(4));
  assign scan_acc = (ctl.phase == lla_pkg::PH_SCAN) && (t != '0)
                    && (32'(t) <= 32'(side_q));

  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = AW'(row_q);
    wr_data   = rd_data ^ onehot;
    sts.last  = 1'b0;
    clear_all = ctl.load && (req.command == lla_pkg::CMD_CLEAR);
    case (ctl.phase)
      lla_pkg::PH_TOGGLE: begin
        rd_en    = (t == '0);
        rd_addr  = AW'(row_q);
        wr_en    = (t == TW'(1)) && in_rng_q && !running;
        sts.last = (t == TW'(1));
      end
      lla_pkg::PH_SCAN: begin
        rd_en    = 32'(t) < 32'(side_q);
        rd_addr  = AW'(t);
        sts.last = 32'(t) == 32'(side_q);
      end
      lla_pkg::PH_STEP: begin
        rd_en    = 32'(t) <= 32'(side_q);
        rd_addr  = (t == '0) ? side_m1 : AW'(t - TW'(1));
        wr_en    = step_wr;
        wr_addr  = AW'(t - TW'(4));
        wr_data  = new_row;
        sts.last = 32'(t) == 32'(side_q) + 3;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      t       <= '0;
    end else begin
      if (ctl.load || ctl.restart) begin
        t <= '0;
      end else if (ctl.phase != lla_pkg::PH_IDLE) begin
        t <= t + TW'(1);
      end
      if (clear_all) begin
        running <= 1'b0;
      end else if (in_step && sts.last) begin
        running <= !(same && !chg) && (alive || new_any);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      side_q   <= side_c;
      row_q    <= req.row;
      col_q    <= req.col;
      in_rng_q <= (32'(req.row) < 32'(side_c)) && (32'(req.col) < 32'(side_c));
      alive    <= 1'b0;
      same     <= (req.command == lla_pkg::CMD_STEP);
      cell_val <= 1'b0;
    end else begin
      if (ctl.phase == lla_pkg::PH_TOGGLE && t == TW'(1) && in_rng_q) begin
        cell_val <= running ? tgl_bit : !tgl_bit;
      end
      if (scan_acc) begin
        alive <= alive | (|(rd_data & col_mask));
      end
      if (step_wr) begin
        alive <= alive | new_any;
        same  <= same & !chg;
      end
    end
    if (in_step && (t != '0) && (32'(t) <= 32'(side_q) + 2)) begin
      win_prev <= win_cur;
      win_cur  <= win_nxt;
      win_nxt  <= (32'(t) <= 32'(side_q) + 1) ? rd_data : row0_q;
    end
    if (in_step && t == TW'(2)) begin
      row0_q <= rd_data;
    end
  end

  assign rsp.running    = running;
  assign rsp.any_alive  = alive;
  assign rsp.unchanged  = same;
  assign rsp.cell_value = cell_val;

  a_wr_phase: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (ctl.phase == lla_pkg::PH_STEP || ctl.phase == lla_pkg::PH_TOGGLE))
    else $error("grid write outside toggle or step");
  a_step_wr_addr: assert property (@(posedge clk) disable iff (rst)
    step_wr |-> (32'(wr_addr) < 32'(side_q)))
    else $error("step write beyond side");
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("row read and written in one cycle");
  a_clear_stops: assert property (@(posedge clk) disable iff (rst)
    clear_all |=> !running)
    else $error("clear left block running");

endmodule

@@ rtl/life_like_automaton_stepper.sv @@
// Life-like automaton on a square torus of up to MAX_SIDE x MAX_SIDE cells.
// Top level: configuration registers, lla_ctrl and lla_datapath; depends on lla_pkg.
//
// Command channel: request is taken at a clock edge with start high and busy low.
// Each command gives one result on result, shown for exactly one cycle with done high;
// the receiver cannot stall it. The next command is taken the cycle after done.
// Configuration channel: cfg_index/cfg_data written when cfg_valid and cfg_ready
// (always high) are both high. Users must write only while busy is low; not enforced.
// What each command does after it is accepted:
//   clear                 straight to done
//   toggle                read-modify-write, then a liveness scan
//   no-op                 liveness scan
//   step                  one grid row per cycle through a three-row window
// Rows of the grid pass through the single read port of the grid store.
// Reset: all cells dead, running low, registers at B3/S23 and side 40; usable
// on the first cycle after reset. Clear kills all cells at once.
module life_like_automaton_stepper #(
  parameter int MAX_SIDE = lla_pkg::MAX_SIDE_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  lla_pkg::req_t request,
  output logic          done,
  output lla_pkg::rsp_t result,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [8:0]    cfg_data
);

  logic [8:0]    birth_mask;
  logic [8:0]    survive_mask;
  logic [7:0]    grid_side;
  lla_pkg::ctl_t ctl;
  lla_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      birth_mask   <= lla_pkg::BIRTH_RST;
      survive_mask <= lla_pkg::SURVIVE_RST;
      grid_side    <= lla_pkg::SIDE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lla_pkg::CFG_BIRTH:   birth_mask   <= cfg_data;
        lla_pkg::CFG_SURVIVE: survive_mask <= cfg_data;
        lla_pkg::CFG_SIDE:    grid_side    <= cfg_data[7:0];
        default:              grid_side    <= grid_side;
      endcase
    end
  end

  lla_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (request.command),
    .sts     (sts),
    .ctl     (ctl),
    .busy    (busy),
    .done    (done)
  );

  lla_datapath #(.MAX_SIDE(MAX_SIDE)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .req          (request),
    .birth_mask   (birth_mask),
    .survive_mask (survive_mask),
    .grid_side    (grid_side),
    .sts          (sts),
    .rsp          (result)
  );

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for life_like_automaton_stepper: commands, rule masks and sides.
// Holds its own torus model of the grid; depends on lla_pkg and the RTL top level.
module testbench;

  localparam int MAXS = 128;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  lla_pkg::req_t request = '0;
  logic done;
  lla_pkg::rsp_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [8:0] cfg_data = '0;

  life_like_automaton_stepper i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state
  bit cells [MAXS][MAXS];
  bit nxt_cells [MAXS][MAXS];
  bit run_flag;
  logic [8:0] birth_rule;
  logic [8:0] survive_rule;
  logic [7:0] side_reg;

  lla_pkg::rsp_t outcome_q[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int idle_cycles = 0;
  bit allow_gaps = 1'b1;

  function automatic int eff_side();
    if (side_reg < 2) return 2;
    if (side_reg > MAXS) return MAXS;
    return side_reg;
  endfunction

  function automatic bit grid_alive(int s);
    for (int r = 0; r < s; r++)
      for (int c = 0; c < s; c++)
        if (cells[r][c]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic lla_pkg::rsp_t predict_outcome(lla_pkg::req_t rq);
    int s;
    bit same;
    int rp, rn, cp, cn, cnt;
    logic [8:0] m;
    lla_pkg::rsp_t o;
    s = eff_side();
    o = '0;
    same = 1'b1;
    case (lla_pkg::cmd_t'(rq.command))
      lla_pkg::CMD_TOGGLE: begin
        if (rq.row < s && rq.col < s) begin
          if (!run_flag) cells[rq.row][rq.col] = !cells[rq.row][rq.col];
          o.cell_value = cells[rq.row][rq.col];
        end
      end
      lla_pkg::CMD_CLEAR: begin
        for (int r = 0; r < MAXS; r++)
          for (int c = 0; c < MAXS; c++) cells[r][c] = 1'b0;
        run_flag = 1'b0;
      end
      lla_pkg::CMD_STEP: begin
        run_flag = 1'b1;
        for (int r = 0; r < s; r++) begin
          rp = (r + s - 1) % s;
          rn = (r + 1) % s;
          for (int c = 0; c < s; c++) begin
            cp = (c + s - 1) % s;
            cn = (c + 1) % s;
            cnt = cells[rp][cp] + cells[rp][c] + cells[rp][cn] + cells[r][cp]
                + cells[r][cn] + cells[rn][cp] + cells[rn][c] + cells[rn][cn];
            m = cells[r][c] ? survive_rule : birth_rule;
            nxt_cells[r][c] = m[cnt];
            if (nxt_cells[r][c] != cells[r][c]) same = 1'b0;
          end
        end
        if (same) begin
          o.unchanged = 1'b1;
          run_flag = 1'b0;
        end else begin
          for (int r = 0; r < s; r++)
            for (int c = 0; c < s; c++) cells[r][c] = nxt_cells[r][c];
          if (!grid_alive(s)) run_flag = 1'b0;
        end
      end
      default: ;
    endcase
    o.running = run_flag;
    o.any_alive = grid_alive(s);
    return o;
  endfunction

  task automatic random_gap();
    if (allow_gaps && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 5)) @(posedge clk);
  endtask

  task automatic issue_command(lla_pkg::cmd_t cmd, int row, int col);
    lla_pkg::req_t rq;
    rq.command = cmd;
    rq.row = row[6:0];
    rq.col = col[6:0];
    random_gap();
    start <= 1'b1;
    request <= rq;
    do @(posedge clk); while (busy);
    outcome_q.push_back(predict_outcome(rq));
    n_sent++;
    start <= 1'b0;
    // busy is high in the cycle after an accept, so this costs no throughput
    @(posedge clk);
  endtask

  task automatic drain();
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (MAXS + 10) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [8:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      lla_pkg::CFG_BIRTH: birth_rule = value;
      lla_pkg::CFG_SURVIVE: survive_rule = value;
      lla_pkg::CFG_SIDE: side_reg = value[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_rule(logic [8:0] b, logic [8:0] sv, logic [7:0] sd);
    drain();
    write_reg(lla_pkg::CFG_BIRTH, b);
    write_reg(lla_pkg::CFG_SURVIVE, sv);
    write_reg(lla_pkg::CFG_SIDE, {1'b0, sd});
    issue_command(lla_pkg::CMD_CLEAR, 0, 0);
  endtask

  // checker
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) idle_cycles <= 0;
      else if (done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (done) begin
        if (outcome_q.size() == 0) begin
          $error("result with no transaction pending");
          errors++;
        end else begin
          lla_pkg::rsp_t e;
          e = outcome_q.pop_front();
          n_checked++;
          if (result.running !== e.running) begin
            $error("running exp %0b got %0b", e.running, result.running); errors++;
          end
          if (result.any_alive !== e.any_alive) begin
            $error("any_alive exp %0b got %0b", e.any_alive, result.any_alive); errors++;
          end
          if (result.unchanged !== e.unchanged) begin
            $error("unchanged exp %0b got %0b", e.unchanged, result.unchanged); errors++;
          end
          if (result.cell_value !== e.cell_value) begin
            $error("cell_value exp %0b got %0b", e.cell_value, result.cell_value); errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic test_directed();
    issue_command(lla_pkg::CMD_NOP, 0, 0);
    issue_command(lla_pkg::CMD_TOGGLE, 0, 0);
    issue_command(lla_pkg::CMD_TOGGLE, 39, 39);
    issue_command(lla_pkg::CMD_TOGGLE, 40, 5);
    issue_command(lla_pkg::CMD_TOGGLE, 127, 127);
    issue_command(lla_pkg::CMD_TOGGLE, 0, 1);
    issue_command(lla_pkg::CMD_TOGGLE, 0, 39);
    issue_command(lla_pkg::CMD_STEP, 0, 0);
    issue_command(lla_pkg::CMD_TOGGLE, 5, 5);
    issue_command(lla_pkg::CMD_STEP, 0, 0);
    issue_command(lla_pkg::CMD_STEP, 0, 0);
    issue_command(lla_pkg::CMD_CLEAR, 0, 0);
    issue_command(lla_pkg::CMD_STEP, 0, 0);
    // blinker, then a block still life
    issue_command(lla_pkg::CMD_TOGGLE, 10, 9);
    issue_command(lla_pkg::CMD_TOGGLE, 10, 10);
    issue_command(lla_pkg::CMD_TOGGLE, 10, 11);
    repeat (2) issue_command(lla_pkg::CMD_STEP, 0, 0);
    issue_command(lla_pkg::CMD_CLEAR, 0, 0);
    issue_command(lla_pkg::CMD_TOGGLE, 2, 2);
    issue_command(lla_pkg::CMD_TOGGLE, 2, 3);
    issue_command(lla_pkg::CMD_TOGGLE, 3, 2);
    issue_command(lla_pkg::CMD_TOGGLE, 3, 3);
    issue_command(lla_pkg::CMD_STEP, 0, 0);
    issue_command(lla_pkg::CMD_NOP, 127, 0);
  endtask

  task automatic test_side_extremes();
    // sides 0 and 1 clamp to 2; 255 and 129 clamp to 128; self-wrap counted
    set_rule(9'h1ff, 9'h000, 8'd0);
    issue_command(lla_pkg::CMD_TOGGLE, 1, 1);
    issue_command(lla_pkg::CMD_TOGGLE, 2, 0);
    issue_command(lla_pkg::CMD_STEP, 0, 0);
    issue_command(lla_pkg::CMD_STEP, 0, 0);
    set_rule(9'h010, 9'h1ff, 8'd1);
    issue_command(lla_pkg::CMD_TOGGLE, 0, 0);
    issue_command(lla_pkg::CMD_STEP, 0, 0);
    set_rule(9'h008, 9'h00c, 8'd255);
    issue_command(lla_pkg::CMD_TOGGLE, 127, 127);
    issue_command(lla_pkg::CMD_TOGGLE, 127, 0);
    issue_command(lla_pkg::CMD_TOGGLE, 0, 127);
    issue_command(lla_pkg::CMD_STEP, 0, 0);
    set_rule(9'h008, 9'h00c, 8'd129);
    issue_command(lla_pkg::CMD_TOGGLE, 64, 64);
    issue_command(lla_pkg::CMD_STEP, 0, 0);
    // side shrinks without clear: stored cells outside stay untouched
    issue_command(lla_pkg::CMD_CLEAR, 0, 0);
    issue_command(lla_pkg::CMD_TOGGLE, 100, 100);
    issue_command(lla_pkg::CMD_TOGGLE, 3, 3);
    drain();
    write_reg(lla_pkg::CFG_SIDE, 9'd8);
    issue_command(lla_pkg::CMD_NOP, 0, 0);
    issue_command(lla_pkg::CMD_STEP, 0, 0);
    drain();
    write_reg(lla_pkg::CFG_SIDE, 9'd128);
    issue_command(lla_pkg::CMD_NOP, 0, 0);
  endtask

  task automatic test_random(int count, bit use_big);
    int sd, left, n;
    left = count;
    while (left > 0) begin
      if (use_big && $urandom_range(0, 9) == 0) sd = $urandom_range(100, 128);
      else sd = $urandom_range(2, 12);
      case ($urandom_range(0, 3))
        0: set_rule(9'h008, 9'h00c, sd[7:0]);
        1: set_rule(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)), sd[7:0]);
        2: set_rule(9'h000, 9'h1ff, sd[7:0]);
        default: set_rule(9'h1ff, 9'h000, sd[7:0]);
      endcase
      if ($urandom_range(0, 4) == 0) begin
        // noise: random commands, random addresses
        n = 30;
        repeat (n) issue_command(lla_pkg::cmd_t'($urandom_range(0, 3)),
                                 $urandom_range(0, 127), $urandom_range(0, 127));
      end else begin
        n = $urandom_range(3, sd < 13 ? sd * sd / 2 : 20);
        repeat (n) issue_command(lla_pkg::CMD_TOGGLE, $urandom_range(0, sd),
                                 $urandom_range(0, sd));
        repeat (10) begin
          issue_command(lla_pkg::CMD_STEP, 0, 0);
          if ($urandom_range(0, 4) == 0)
            issue_command(lla_pkg::CMD_TOGGLE, $urandom_range(0, sd - 1),
                          $urandom_range(0, sd - 1));
        end
        n += 10;
      end
      left -= n;
    end
  endtask

  initial begin
    birth_rule = lla_pkg::BIRTH_RST;
    survive_rule = lla_pkg::SURVIVE_RST;
    side_reg = lla_pkg::SIDE_RST;
    run_flag = 1'b0;
    foreach (cells[r, c]) cells[r][c] = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_side_extremes();
    test_random(1500, 1'b1);
    allow_gaps = 1'b0;
    test_random(300, 1'b0);
    drain();
    $display("sent %0d commands, checked %0d results", n_sent, n_checked);
    $display("covered toggles, clears, steps and no-ops over clamped sides and random rules");
    if (errors == 0 && outcome_q.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule

@@ life_like_automaton_stepper.f @@
rtl/lla_pkg.sv
rtl/lla_grid_mem.sv
rtl/lla_ctrl.sv
rtl/lla_datapath.sv
rtl/life_like_automaton_stepper.sv
dv/testbench.sv
